>>> hw/rtl/mts_pkg.sv
package mts_pkg;

   localparam int DEFAULT_STACK_DEPTH = 64;

   typedef logic signed [31:0] word_type;

   // One stack level: the stored value and the minimum of it and every level below it.
   typedef struct packed {
      word_type value;
      word_type minimum;
   } entry_type;

   // Shift control that every cell of the chain sees in the same cycle.
   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

endpackage

>>> hw/rtl/min_tracking_stack_unit.sv
// Stack of signed 32-bit values that reports its minimum with every response. Each request is
// a push or a pop and gives exactly one response with the new top, the new minimum (both 0 when
// the stack is empty), an empty flag and a status: overflow for a push onto a full stack, which
// is dropped, and underflow for a pop on an empty stack, which is ignored. The stack is a chain
// of STACK_DEPTH cells, top first; each cell keeps its value together with the minimum of itself
// and everything below it, and the whole chain shifts by one level on a push or a pop. A request
// is taken in every cycle in which the response register is empty or being drained, so the
// block sustains one request per clock; a response appears in the cycle after its request.
module min_tracking_stack_unit
   import mts_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  word_type    req_push_value,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output word_type    rsp_top_value,
   output word_type    rsp_min_value,
   output logic        rsp_is_empty,
   output logic [1:0]  rsp_status
);

   localparam int CountWidth = $clog2(STACK_DEPTH + 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(STACK_DEPTH);
   localparam logic [CountWidth-1:0] OneCount  = CountWidth'(1);

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   word_type   top_value_ff;
   word_type   top_value_in;
   word_type   min_value_ff;
   word_type   min_value_in;
   logic       is_empty_ff;
   logic       is_empty_in;
   logic [1:0] status_ff;
   logic [1:0] status_in;

   entry_type cell_entry [STACK_DEPTH];
   entry_type new_entry;
   shift_type shift;

   logic accept;
   logic is_full;
   logic is_zero;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == FullCount);
   assign is_zero   = (count_ff == '0);

   assign shift.push = accept && (req_command == CMD_PUSH) && !is_full;
   assign shift.pop  = accept && (req_command == CMD_POP) && !is_zero;

   always_comb begin
      new_entry.value = req_push_value;
      if (is_zero || (req_push_value <= cell_entry[0].minimum)) begin
         new_entry.minimum = req_push_value;
      end else begin
         new_entry.minimum = cell_entry[0].minimum;
      end
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      entry_type upper;
      entry_type lower;
      if (i == 0) begin : g_top
         assign upper = new_entry;
      end else begin : g_inner_up
         assign upper = cell_entry[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign lower = '0;
      end else begin : g_inner_down
         assign lower = cell_entry[i+1];
      end
      mts_cell u_cell (
         .clock        (clock),
         .shift        (shift),
         .upper_entry  (upper),
         .lower_entry  (lower),
         .stored_entry (cell_entry[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (shift.push) begin
         count_in = count_ff + OneCount;
      end else if (shift.pop) begin
         count_in = count_ff - OneCount;
      end
   end

   // The response describes the stack after the request, read from the cells or, for a kept push, from the new entry.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      top_value_in = top_value_ff;
      min_value_in = min_value_ff;
      is_empty_in  = is_empty_ff;
      status_in    = status_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_OK;
         if (req_command == CMD_PUSH) begin
            is_empty_in = 1'b0;
            if (is_full) begin
               status_in    = STATUS_OVERFLOW;
               top_value_in = cell_entry[0].value;
               min_value_in = cell_entry[0].minimum;
            end else begin
               top_value_in = new_entry.value;
               min_value_in = new_entry.minimum;
            end
         end else begin
            if (is_zero || count_ff == OneCount) begin
               if (is_zero) begin
                  status_in = STATUS_UNDERFLOW;
               end
               is_empty_in  = 1'b1;
               top_value_in = '0;
               min_value_in = '0;
            end else begin
               is_empty_in  = 1'b0;
               top_value_in = cell_entry[1].value;
               min_value_in = cell_entry[1].minimum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_value_ff <= top_value_in;
      min_value_ff <= min_value_in;
      is_empty_ff  <= is_empty_in;
      status_ff    <= status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = top_value_ff;
   assign rsp_min_value = min_value_ff;
   assign rsp_is_empty  = is_empty_ff;
   assign rsp_status    = status_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("stack count exceeds the depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      shift.push |=> count_ff == $past(count_ff) + OneCount)
      else $error("accepted push did not grow the stack");

   a_empty_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && is_empty_ff) |-> (top_value_ff == '0 && min_value_ff == '0))
      else $error("empty response carries nonzero top or minimum");

   a_min_not_above_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !is_empty_ff) |-> (min_value_ff <= top_value_ff))
      else $error("reported minimum is above the top value");

   a_empty_matches_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> (is_empty_ff == (count_ff == '0)))
      else $error("empty flag disagrees with the stack count");

endmodule

>>> hw/rtl/mts_cell.sv
module mts_cell
   import mts_pkg::*;
(
   input  logic      clock,
   input  shift_type shift,
   input  entry_type upper_entry,
   input  entry_type lower_entry,
   output entry_type stored_entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // A push moves every level one step down; a pop moves every level one step up.
   always_comb begin
      entry_in = entry_ff;
      if (shift.push) begin
         entry_in = upper_entry;
      end else if (shift.pop) begin
         entry_in = lower_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign stored_entry = entry_ff;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mts_pkg::*;

   localparam int STACK_DEPTH    = DEFAULT_STACK_DEPTH;
   localparam int TOTAL_REQUESTS = 1800;
   localparam int IDLE_LIMIT     = 2000;
   localparam int REPORT_LIMIT   = 10;

   localparam word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   typedef struct {
      word_type   top_value;
      word_type   min_value;
      logic       is_empty;
      logic [1:0] status;
   } stack_view_type;

   typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_SLOW, DRAIN_PERIODIC} drain_mode_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_command;
   word_type   req_push_value;
   logic       rsp_valid;
   logic       rsp_ready;
   word_type   rsp_top_value;
   word_type   rsp_min_value;
   logic       rsp_is_empty;
   logic [1:0] rsp_status;

   // Mirror of the stack contents and the running minima.
   word_type value_mirror[STACK_DEPTH];
   word_type minima_mirror[STACK_DEPTH];
   int       value_depth = 0;
   int       minima_depth = 0;

   stack_view_type views_due[$];
   int             error_count = 0;
   int             requests_sent = 0;
   int             burst_left = 0;
   int             idle_cycles = 0;

   min_tracking_stack_unit #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_top_value  (rsp_top_value),
      .rsp_min_value  (rsp_min_value),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void report_error(string text);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("ERROR at %0t: %s", $time, text);
      end
   endfunction

   // Applies one request to the mirror and returns the stack as it should look afterwards.
   function automatic stack_view_type apply_stack_op(logic command, word_type value);
      stack_view_type view;
      word_type       popped;
      view.status = STATUS_OK;
      if (command == CMD_PUSH) begin
         if (value_depth >= STACK_DEPTH) begin
            view.status = STATUS_OVERFLOW;
         end else begin
            value_mirror[value_depth] = value;
            value_depth++;
            if (minima_depth == 0 || value <= minima_mirror[minima_depth - 1]) begin
               minima_mirror[minima_depth] = value;
               minima_depth++;
            end
         end
      end else begin
         if (value_depth == 0) begin
            view.status = STATUS_UNDERFLOW;
         end else begin
            popped = value_mirror[value_depth - 1];
            value_depth--;
            if (minima_depth > 0 && popped == minima_mirror[minima_depth - 1]) begin
               minima_depth--;
            end
         end
      end
      view.top_value = (value_depth > 0) ? value_mirror[value_depth - 1] : '0;
      view.min_value = (value_depth > 0 && minima_depth > 0) ?
                       minima_mirror[minima_depth - 1] : '0;
      view.is_empty  = (value_depth == 0);
      return view;
   endfunction

   // Mix of full-range values, crowded small values that collide often, and corner values.
   function automatic word_type pick_value();
      case ($urandom_range(0, 4))
         0, 1: return word_type'($urandom);
         2: return word_type'(int'($urandom_range(0, 8)) - 4);
         3: begin
            case ($urandom_range(0, 3))
               0: return WORD_MAX;
               1: return WORD_MIN;
               2: return '0;
               default: return -32'sd1;
            endcase
         end
         default: return word_type'(int'($urandom_range(0, 200)) - 100);
      endcase
   endfunction

   task automatic send_request(input logic command, input word_type value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_command    <= command;
      req_push_value <= value;
      do @(posedge clock); while (!req_ready);
      views_due.push_back(apply_stack_op(command, value));
      requests_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (views_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_stack();
      send_request(CMD_POP, '0);
      send_request(CMD_POP, WORD_MAX);
      send_request(CMD_PUSH, '0);
      send_request(CMD_POP, WORD_MIN);
      send_request(CMD_POP, -32'sd1);
   endtask

   task automatic test_value_extremes();
      send_request(CMD_PUSH, WORD_MAX);
      send_request(CMD_PUSH, WORD_MIN);
      send_request(CMD_PUSH, -32'sd1);
      send_request(CMD_PUSH, WORD_MIN);
      send_request(CMD_PUSH, WORD_MAX);
      repeat (5) send_request(CMD_POP, '0);
   endtask

   // Equal values must stack up on the minima side so that popping one copy keeps the other.
   task automatic test_repeated_minimum();
      send_request(CMD_PUSH, 32'sd5);
      send_request(CMD_PUSH, 32'sd5);
      send_request(CMD_PUSH, 32'sd3);
      send_request(CMD_PUSH, 32'sd3);
      send_request(CMD_PUSH, 32'sd7);
      repeat (5) send_request(CMD_POP, 32'sd3);
   endtask

   task automatic test_full_stack();
      while (value_depth < STACK_DEPTH) send_request(CMD_PUSH, pick_value());
      repeat (3) send_request(CMD_PUSH, pick_value());
      while (value_depth > 0) send_request(CMD_POP, pick_value());
      send_request(CMD_POP, pick_value());
   endtask

   task automatic test_random_mix();
      int push_percent;
      int phase_len;
      while (requests_sent < TOTAL_REQUESTS) begin
         case ($urandom_range(0, 2))
            0: push_percent = 85;
            1: push_percent = 50;
            default: push_percent = 15;
         endcase
         phase_len = $urandom_range(30, 150);
         repeat (phase_len) begin
            send_request(($urandom_range(1, 100) <= push_percent) ? CMD_PUSH : CMD_POP,
                         pick_value());
         end
         if ($urandom_range(0, 4) == 0) begin
            wait_drained();
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = CMD_PUSH;
      req_push_value = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_stack();
      test_value_extremes();
      test_repeated_minimum();
      wait_drained();
      test_full_stack();
      wait_drained();
      test_random_mix();

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // The response side switches between several stall patterns of random length.
   initial begin
      drain_mode_type mode;
      int             span;
      int             tick;
      rsp_ready = 1'b0;
      tick = 0;
      forever begin
         mode = drain_mode_type'($urandom_range(0, 3));
         span = $urandom_range(20, 150);
         repeat (span) begin
            @(negedge clock);
            tick++;
            case (mode)
               DRAIN_FREE:  rsp_ready <= 1'b1;
               DRAIN_COIN:  rsp_ready <= ($urandom_range(0, 1) == 1);
               DRAIN_SLOW:  rsp_ready <= ($urandom_range(0, 4) == 0);
               default:     rsp_ready <= (tick % 4 != 3);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_responses
      stack_view_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (views_due.size() == 0) begin
            report_error("response with no request outstanding");
         end else begin
            due = views_due.pop_front();
            if (rsp_top_value !== due.top_value) begin
               report_error($sformatf("top_value expected %0d, got %0d",
                                      due.top_value, rsp_top_value));
            end
            if (rsp_min_value !== due.min_value) begin
               report_error($sformatf("min_value expected %0d, got %0d",
                                      due.min_value, rsp_min_value));
            end
            if (rsp_is_empty !== due.is_empty) begin
               report_error($sformatf("is_empty expected %0b, got %0b",
                                      due.is_empty, rsp_is_empty));
            end
            if (rsp_status !== due.status) begin
               report_error($sformatf("status expected %0d, got %0d",
                                      due.status, rsp_status));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

endmodule
